### rtl/core/cdus_pkg.sv
// ----------------------------------------------------------------------------
// cdus_pkg
// Types, constants and helpers for the cookie date parser.
// ----------------------------------------------------------------------------
package cdus_pkg;

  localparam int unsigned CharWidth = 8;
  localparam int unsigned SecWidth  = 38;
  localparam int unsigned NumWidth  = 14;
  localparam int unsigned NumSat    = 16383;
  localparam int unsigned LenSat    = 15;
  localparam int unsigned DaysWidth = 22;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_YEAR  = 6'b000010,
    ST_DAYS  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_SUM   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic split_year;
    logic start_days;
    logic do_mul;
    logic do_sum;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last_seen;
  } status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [3:0] month_code(input logic [23:0] s);
    case (s)
      "jan": return 4'd1;
      "feb": return 4'd2;
      "mar": return 4'd3;
      "apr": return 4'd4;
      "may": return 4'd5;
      "jun": return 4'd6;
      "jul": return 4'd7;
      "aug": return 4'd8;
      "sep": return 4'd9;
      "oct": return 4'd10;
      "nov": return 4'd11;
      "dec": return 4'd12;
      default: return 4'd0;
    endcase
  endfunction

endpackage

### rtl/core/cdus_if.sv
// ----------------------------------------------------------------------------
// cdus_in_if / cdus_out_if
// Valid/ready channels for date bytes and parse results.
// ----------------------------------------------------------------------------
interface cdus_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;
  modport source (output valid, char_byte, last_byte, input ready);
  modport sink (input valid, char_byte, last_byte, output ready);
endinterface

interface cdus_out_if;
  logic        valid;
  logic        ready;
  logic        date_valid;
  logic [37:0] unix_seconds;
  modport source (output valid, date_valid, unix_seconds, input ready);
  modport sink (input valid, date_valid, unix_seconds, output ready);
endinterface

### rtl/core/cdus_ctrl.sv
// ----------------------------------------------------------------------------
// cdus_ctrl
// Sequencer: byte intake, then date conversion steps, then result hand-off.
// ----------------------------------------------------------------------------
module cdus_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cdus_pkg::status_t status,
  output cdus_pkg::cmd_t    cmd
);
  import cdus_pkg::*;

  state_t state, state_next;
  logic   out_full;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = out_full;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.take_byte  = in_valid && in_ready;
    case (state)
      ST_IDLE: begin
        if (cmd.take_byte && status.last_seen) begin
          state_next = ST_YEAR;
        end
      end
      ST_YEAR: begin
        cmd.split_year = 1'b1;
        state_next     = ST_DAYS;
      end
      ST_DAYS: begin
        cmd.start_days = 1'b1;
        state_next     = ST_MUL;
      end
      ST_MUL: begin
        cmd.do_mul = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.do_sum = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_full || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/cdus_dp.sv
// ----------------------------------------------------------------------------
// cdus_dp
// Tokenizer state, field capture and days/seconds arithmetic.
// ----------------------------------------------------------------------------
module cdus_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [cdus_pkg::CharWidth-1:0]   char_byte,
  input  logic                             last_byte,
  input  cdus_pkg::cmd_t                   cmd,
  output cdus_pkg::status_t                status,
  output logic                             date_valid,
  output logic [cdus_pkg::SecWidth-1:0]    unix_seconds
);
  import cdus_pkg::*;

  logic [7:0]          token_chars [8];
  logic [3:0]          token_length;
  logic                token_all_digits;
  logic [NumWidth-1:0] token_number;
  logic [6:0]          hour_value, minute_value, second_value;
  logic                time_seen;
  logic [3:0]          month_number;
  logic [1:0]          number_count;
  logic [NumWidth-1:0] first_number, second_number;

  logic [7:0]  c;
  logic        sep, dig;
  logic [17:0] num_ext;
  logic [NumWidth-1:0] num_next;

  assign status.last_seen = last_byte;

  always_comb begin
    c = char_byte;
    if (char_byte >= 8'h41 && char_byte <= 8'h5a) begin
      c = char_byte + 8'd32;
    end
    sep     = (c == 8'h20) || (c == 8'h2c) || (c == 8'h2d);
    dig     = is_digit(c);
    num_ext = {4'd0, token_number} * 18'd10 + {14'd0, c[3:0]};
    num_next = (num_ext > 18'(NumSat)) ? NumWidth'(NumSat) : num_ext[NumWidth-1:0];
  end

  // Token state after taking in the current byte (separator leaves it as is).
  logic [7:0]          tc [8];
  logic [3:0]          tl;
  logic                tad;
  logic [NumWidth-1:0] tn;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tc[i] = token_chars[i];
    end
    tl  = token_length;
    tad = token_all_digits;
    tn  = token_number;
    if (!sep) begin
      if (token_length < 4'd8) begin
        tc[token_length[2:0]] = c;
      end
      if (token_length < 4'(LenSat)) begin
        tl = token_length + 4'd1;
      end
      if (dig) begin
        tn = num_next;
      end else begin
        tad = 1'b0;
      end
    end
  end

  // Token end, applied to (ec,el,ead,en).
  function automatic logic [6:0] two(input logic [7:0] a, input logic [7:0] b);
    return 7'(a[3:0]) * 7'd10 + 7'(b[3:0]);
  endfunction

  logic end_now;
  logic [7:0]          ec [8];
  logic [3:0]          el;
  logic                ead;
  logic [NumWidth-1:0] en;
  logic                tshape, tgood;
  logic [3:0]          mfound;
  logic [6:0]          h_n, m_n, s_n;
  logic                ts_n;
  logic [3:0]          mon_n;
  logic [1:0]          cnt_n;
  logic [NumWidth-1:0] f_n, s2_n;

  always_comb begin
    end_now = sep || last_byte;
    for (int i = 0; i < 8; i++) begin
      ec[i] = sep ? token_chars[i] : tc[i];
    end
    el  = sep ? token_length : tl;
    ead = sep ? token_all_digits : tad;
    en  = sep ? token_number : tn;
    tshape = (el >= 4'd8) && (ec[2] == 8'h3a) && (ec[5] == 8'h3a);
    tgood  = is_digit(ec[0]) && is_digit(ec[1]) && is_digit(ec[3]) &&
             is_digit(ec[4]) && is_digit(ec[6]) && is_digit(ec[7]);
    mfound = (el == 4'd3) ? month_code({ec[0], ec[1], ec[2]}) : 4'd0;
    h_n = hour_value; m_n = minute_value; s_n = second_value; ts_n = time_seen;
    mon_n = month_number; cnt_n = number_count; f_n = first_number;
    s2_n = second_number;
    if (el != 4'd0) begin
      if (tshape) begin
        if (tgood) begin
          h_n = two(ec[0], ec[1]);
          m_n = two(ec[3], ec[4]);
          s_n = two(ec[6], ec[7]);
          ts_n = 1'b1;
        end
      end else if (mfound != 4'd0) begin
        mon_n = mfound;
      end else if (ead) begin
        if (number_count == 2'd0) f_n = en;
        else if (number_count == 2'd1) s2_n = en;
        if (number_count != 2'd3) cnt_n = number_count + 2'd1;
      end
    end
  end

  // Conversion registers.
  logic        valid_r;
  logic [13:0] year_r;
  logic [4:0]  day_r;
  logic [3:0]  mon_r;
  logic [6:0]  hh_r, mm_r, ss_r;
  logic [4:0]  era_r;
  logic [8:0]  yoe_r;
  logic [8:0]  doy_r;
  logic [DaysWidth-1:0] days_r;
  logic [SecWidth-1:0]  dsec_r, tsec_r;

  logic [13:0] yr_adj;
  logic        v_comb;
  always_comb begin
    yr_adj = s2_n;
    if (s2_n < 14'd100) begin
      yr_adj = s2_n + ((s2_n >= 14'd50) ? 14'd1900 : 14'd2000);
    end
    v_comb = ts_n && (mon_n >= 4'd1) && (mon_n <= 4'd12) && (cnt_n == 2'd2) &&
             (f_n >= 14'd1) && (f_n <= 14'd31) && (yr_adj >= 14'd1970) &&
             (yr_adj <= 14'd9999);
  end

  // Days before the month, year starting in March.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    case (m)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd61;
      4'd3:    return 9'd92;
      4'd4:    return 9'd122;
      4'd5:    return 9'd153;
      4'd6:    return 9'd184;
      4'd7:    return 9'd214;
      4'd8:    return 9'd245;
      4'd9:    return 9'd275;
      4'd10:   return 9'd306;
      4'd11:   return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

  // Days since epoch; year < 10000 so eras are small.
  // Era by reciprocal multiply: exact for years below 10000.
  logic [13:0] y;
  logic [3:0]  mp;
  logic [26:0] era_prod;
  logic [4:0]  era;
  logic [13:0] yoe_full;
  logic [8:0]  doy;
  always_comb begin
    y        = (mon_r <= 4'd2) ? year_r - 14'd1 : year_r;
    mp       = (mon_r > 4'd2) ? mon_r - 4'd3 : mon_r + 4'd9;
    era_prod = 27'(y) * 27'd5243;
    era      = era_prod[25:21];
    yoe_full = y - 14'(era) * 14'd400;
    doy      = month_start(mp) + 9'(day_r) - 9'd1;
  end

  logic [1:0]  cent;
  logic [18:0] doe;
  logic [23:0] dtot;
  always_comb begin
    if (yoe_r >= 9'd300) cent = 2'd3;
    else if (yoe_r >= 9'd200) cent = 2'd2;
    else if (yoe_r >= 9'd100) cent = 2'd1;
    else cent = 2'd0;
    doe  = 19'(yoe_r) * 19'd365 + 19'(yoe_r[8:2]) - 19'(cent) + 19'(doy_r);
    dtot = 24'(era_r) * 24'd146097 + 24'(doe) - 24'd719468;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_length <= '0; token_all_digits <= 1'b1; token_number <= '0;
      hour_value <= '0; minute_value <= '0; second_value <= '0;
      time_seen <= 1'b0; month_number <= '0; number_count <= '0;
      first_number <= '0; second_number <= '0;
    end else if (cmd.take_byte) begin
      for (int i = 0; i < 8; i++) begin
        token_chars[i] <= tc[i];
      end
      if (last_byte) begin
        token_length <= '0; token_all_digits <= 1'b1; token_number <= '0;
        hour_value <= '0; minute_value <= '0; second_value <= '0;
        time_seen <= 1'b0; month_number <= '0; number_count <= '0;
        first_number <= '0; second_number <= '0;
        valid_r <= v_comb;
        year_r  <= yr_adj;
        day_r   <= f_n[4:0];
        mon_r   <= mon_n;
        hh_r <= h_n; mm_r <= m_n; ss_r <= s_n;
      end else if (end_now) begin
        token_length <= '0; token_all_digits <= 1'b1; token_number <= '0;
        hour_value <= h_n; minute_value <= m_n; second_value <= s_n;
        time_seen <= ts_n; month_number <= mon_n; number_count <= cnt_n;
        first_number <= f_n; second_number <= s2_n;
      end else begin
        token_length <= tl; token_all_digits <= tad; token_number <= tn;
      end
    end
    if (cmd.split_year) begin
      era_r <= era;
      yoe_r <= yoe_full[8:0];
      doy_r <= doy;
    end
    if (cmd.start_days) begin
      days_r <= dtot[DaysWidth-1:0];
    end
    if (cmd.do_mul) begin
      dsec_r <= SecWidth'(days_r) * SecWidth'(17'd86400);
      tsec_r <= SecWidth'(hh_r) * SecWidth'(12'd3600) +
                SecWidth'(mm_r) * SecWidth'(6'd60) + SecWidth'(ss_r);
    end
    if (cmd.do_sum) begin
      dsec_r <= dsec_r + tsec_r;
    end
    if (cmd.load_out) begin
      date_valid   <= valid_r;
      unix_seconds <= valid_r ? dsec_r : '0;
    end
  end

endmodule

### rtl/core/cookie_date_to_unix_seconds_unit.sv
// ----------------------------------------------------------------------------
// cookie_date_to_unix_seconds_unit
// Parses a cookie date string into Unix seconds.
// ----------------------------------------------------------------------------
// Usage: bytes of the date text arrive on in_ch (char_byte, last_byte) with a
// valid/ready request each. Ordinary bytes are taken one per cycle with no
// result. The byte flagged last closes the string; the block then stops taking
// bytes while the sequencer converts the date (year split, days count, seconds
// multiply, sum, output load). One result request (date_valid, unix_seconds)
// appears on out_ch after the output load. The result sits in an output
// register; if the receiver stalls, the block resumes byte intake anyway. The
// next string's conversion then waits at the output load, with intake stopped,
// until the previous result is taken. Reset (rst, synchronous) clears the
// token counters and captured fields and drops any pending result.
// ----------------------------------------------------------------------------
module cookie_date_to_unix_seconds_unit (
  input logic      clk,
  input logic      rst,
  cdus_in_if.sink  in_ch,
  cdus_out_if.source out_ch
);
  import cdus_pkg::*;

  cmd_t    cmd;
  status_t status;

  cdus_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cdus_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .char_byte    (in_ch.char_byte),
    .last_byte    (in_ch.last_byte),
    .cmd          (cmd),
    .status       (status),
    .date_valid   (out_ch.date_valid),
    .unix_seconds (out_ch.unix_seconds)
  );

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.split_year, cmd.start_days, cmd.do_mul, cmd.do_sum, cmd.load_out}))
    else $error("conversion steps overlap");

  a_no_intake_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.split_year || cmd.start_days || cmd.do_mul || cmd.do_sum) |-> !in_ch.ready)
    else $error("byte taken during conversion");

  a_unix_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.date_valid) |-> (out_ch.unix_seconds == '0))
    else $error("seconds nonzero on invalid date");

endmodule
